/* sv/hpcf_pkg.sv */
// hpcf_pkg: shared types, opcodes and fixed-point helpers for the Hertz pair contact block.
// Used by hpcf_alu and hertz_pair_contact_force_top; no dependencies.
package hpcf_pkg;

  // shared unit opcodes
  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  // register indexes
  localparam logic [1:0] REG_MODULUS  = 2'd0;
  localparam logic [1:0] REG_DAMPING  = 2'd1;
  localparam logic [1:0] REG_FRICTION = 2'd2;

  localparam logic [19:0] MODULUS_RST  = 20'd109890;
  localparam logic [15:0] DAMPING_RST  = 16'd6554;
  localparam logic [15:0] FRICTION_RST = 16'd6554;

  // floor(2^32/48) and 2^40/sqrt(1e9)
  localparam logic [63:0] KQ48 = 64'd89478485;
  localparam logic [63:0] CQ   = 64'd34769611;
  localparam logic [63:0] FCAP = 64'h3FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic        start;
    logic [1:0]  op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] lo;
    logic [63:0] hi;
  } alu_rsp_t;

  // (product >> sh) clipped to FCAP; bit 64 flags the clip
  function automatic logic [64:0] mulsh(logic [127:0] p, logic [5:0] sh);
    logic [127:0] s;
    s = p >> sh;
    if (s[127:62] != '0) return {1'b1, FCAP};
    return {1'b0, s[63:0]};
  endfunction

  function automatic logic signed [63:0] signed_of(logic [63:0] m, logic neg);
    return neg ? -$signed(m) : $signed(m);
  endfunction

endpackage

/* sv/hpcf_alu.sv */
// hpcf_alu: shared iterative unit - 64x64 multiply from 32x32 partials,
// restoring 64-bit divide and 32-bit-root square root. Depends on hpcf_pkg.
module hpcf_alu import hpcf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic         busy;
  logic         done;
  logic [1:0]   op_r;
  logic [5:0]   cnt;
  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [63:0]  num;
  logic [127:0] acc;
  logic [63:0]  prod;
  logic [1:0]   psh;
  logic [63:0]  quo;
  logic [64:0]  rem;
  logic [35:0]  srem;
  logic [31:0]  root;
  logic         last_step;
  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [127:0] part;
  logic [64:0]  rem_sh;
  logic [35:0]  srem_sh;
  logic [35:0]  trial;

  always_comb begin
    unique case (op_r)
      OP_MUL:  last_step = (cnt == 6'd4);
      OP_DIV:  last_step = (cnt == 6'd63);
      OP_SQRT: last_step = (cnt == 6'd31);
      default: last_step = 1'b1;
    endcase
    pa      = cnt[0] ? a_r[63:32] : a_r[31:0];
    pb      = cnt[1] ? b_r[63:32] : b_r[31:0];
    case (psh)
      2'd0:    part = 128'(prod);
      2'd3:    part = 128'(prod) << 64;
      default: part = 128'(prod) << 32;
    endcase
    rem_sh  = {rem[63:0], num[63]};
    srem_sh = {srem[33:0], num[63:62]};
    trial   = {2'b00, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op_r <= OP_MUL;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op_r <= req.op;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (last_step) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r  <= req.a;
      b_r  <= req.b;
      num  <= req.a;
      acc  <= '0;
      quo  <= '0;
      rem  <= '0;
      srem <= '0;
      root <= '0;
    end else if (busy) begin
      unique case (op_r)
        OP_MUL: begin
          if (cnt < 6'd4) begin
            prod <= 64'(pa) * 64'(pb);
            psh  <= cnt[1:0];
          end
          if (cnt != 6'd0) acc <= acc + part;
        end
        OP_DIV: begin
          num <= num << 1;
          if (rem_sh >= {1'b0, b_r}) begin
            rem <= rem_sh - {1'b0, b_r};
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[62:0], 1'b0};
          end
        end
        OP_SQRT: begin
          num <= num << 2;
          if (srem_sh >= trial) begin
            srem <= srem_sh - trial;
            root <= {root[30:0], 1'b1};
          end else begin
            srem <= srem_sh;
            root <= {root[30:0], 1'b0};
          end
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.hi   = acc[127:64];
    unique case (op_r)
      OP_DIV:  rsp.lo = quo;
      OP_SQRT: rsp.lo = 64'(root);
      default: rsp.lo = acc[63:0];
    endcase
  end

endmodule

/* sv/hertz_pair_contact_force_top.sv */
// Hertz pair contact force top: sequencer, pair state and running force sums.
// Depends on hpcf_pkg and hpcf_alu (shared multiply/divide/root unit).
//
//  channel  | direction | transfer when            | contents
//  s_*      | in        | s_tvalid & s_tready      | one neighbour pair
//  m_*      | out       | m_tvalid & m_tready      | summed forces on last pair
//  cfg_*    | in        | cfg_we                   | modulus, damping, friction
//
// A self pair goes straight to the end state and a pair out of contact stops after the
// separation test; a contacting pair runs nine divides, five roots and 31 multiplies on the
// single shared unit in turn; fewer when both masses or the tangential part are zero.
// s_tready is high only while the sequencer is idle. The result sits in an output
// register, so the next pair is taken while it waits; a later last pair stalls
// only if that register is still full. Reset is synchronous and clears the sums.
module hertz_pair_contact_force_top import hpcf_pkg::*; #(
  parameter int SUM_WIDTH = 48
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [19:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // rel_pos_x, rel_pos_y, rel_pos_z, rel_vel_x, rel_vel_y, rel_vel_z,
  // radius_self, radius_other, mass_self, mass_other
  input  logic [319:0] s_tdata,
  input  logic         s_tuser,   // is_self
  input  logic         s_tlast,   // last_pair
  output logic         m_tvalid,
  input  logic         m_tready,
  // contact_force_x/y/z, friction_force_x/y/z
  output logic [287:0] m_tdata,
  output logic         m_tuser    // saturated
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_D2   = 5'd1;
  localparam logic [4:0] ST_SS   = 5'd2;
  localparam logic [4:0] ST_SQD  = 5'd3;
  localparam logic [4:0] ST_RR   = 5'd4;
  localparam logic [4:0] ST_RQ8  = 5'd5;
  localparam logic [4:0] ST_RD   = 5'd6;
  localparam logic [4:0] ST_SQA  = 5'd7;
  localparam logic [4:0] ST_ED   = 5'd8;
  localparam logic [4:0] ST_AK   = 5'd9;
  localparam logic [4:0] ST_FE   = 5'd10;
  localparam logic [4:0] ST_MD   = 5'd11;
  localparam logic [4:0] ST_MS   = 5'd12;
  localparam logic [4:0] ST_EM   = 5'd13;
  localparam logic [4:0] ST_SQG  = 5'd14;
  localparam logic [4:0] ST_GC   = 5'd15;
  localparam logic [4:0] ST_TZ   = 5'd16;
  localparam logic [4:0] ST_SQB  = 5'd17;
  localparam logic [4:0] ST_TB   = 5'd18;
  localparam logic [4:0] ST_VD   = 5'd19;
  localparam logic [4:0] ST_VN   = 5'd20;
  localparam logic [4:0] ST_FD   = 5'd21;
  localparam logic [4:0] ST_NQ   = 5'd22;
  localparam logic [4:0] ST_CF   = 5'd23;
  localparam logic [4:0] ST_PM   = 5'd24;
  localparam logic [4:0] ST_SH   = 5'd25;
  localparam logic [4:0] ST_T2   = 5'd26;
  localparam logic [4:0] ST_SQT  = 5'd27;
  localparam logic [4:0] ST_FF   = 5'd28;
  localparam logic [4:0] ST_U    = 5'd29;
  localparam logic [4:0] ST_FR   = 5'd30;
  localparam logic [4:0] ST_DONE = 5'd31;

  localparam logic signed [65:0] SUM_MAX = (66'sd1 <<< (SUM_WIDTH - 1)) - 66'sd1;
  localparam logic signed [65:0] SUM_MIN = -SUM_MAX - 66'sd1;

  function automatic logic [SUM_WIDTH:0] sat_add(logic signed [SUM_WIDTH-1:0] s,
                                                  logic signed [63:0] x);
    logic signed [65:0] r;
    r = 66'(s) + 66'(x);
    if (r > SUM_MAX) return {1'b1, SUM_MAX[SUM_WIDTH-1:0]};
    if (r < SUM_MIN) return {1'b1, SUM_MIN[SUM_WIDTH-1:0]};
    return {1'b0, r[SUM_WIDTH-1:0]};
  endfunction

  alu_req_t req;
  alu_rsp_t rsp;

  hpcf_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  logic [4:0]  state;
  logic        issued;
  logic [1:0]  k;
  logic [19:0] modulus;
  logic [15:0] damping;
  logic [15:0] friction;

  logic signed [SUM_WIDTH-1:0] contact_sum [3];
  logic signed [SUM_WIDTH-1:0] friction_sum [3];
  logic                        clip_flag;

  // pair operands
  logic [31:0]        ad [3];
  logic               dneg [3];
  logic signed [31:0] vs [3];
  logic [31:0]        vm [3];
  logic               vneg [3];
  logic [23:0]        rs;
  logic [23:0]        ro;
  logic [39:0]        ms;
  logic [39:0]        mo;
  logic               last;

  // intermediates
  logic [63:0]        d2;
  logic [24:0]        s_sum;
  logic [31:0]        centre_dist;
  logic [24:0]        delta;
  logic [63:0]        rq8;
  logic [31:0]        a_root;
  logic [63:0]        ea;
  logic [63:0]        tmp;
  logic [63:0]        fe;
  logic [63:0]        mstar;
  logic [63:0]        damp_t;
  logic [31:0]        b_root;
  logic [63:0]        tb;
  logic signed [63:0] vd;
  logic [63:0]        vnm;
  logic signed [63:0] fn;
  logic [63:0]        nq;
  logic [63:0]        at [3];
  logic               tneg [3];
  logic [63:0]        s2;
  logic [31:0]        tn;
  logic [63:0]        ff;

  logic [39:0]  big;
  logic [39:0]  small_m;
  logic [63:0]  fnm;
  logic [63:0]  vdm;
  logic         is_arith;
  logic         skip_md;
  logic [5:0]   sh_amt;
  logic [64:0]  msh;
  logic [SUM_WIDTH-1:0] sat_s;
  logic signed [63:0]   sat_x;
  logic [SUM_WIDTH:0]   sat;
  logic signed [63:0]   t_new;
  logic                 t_big;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    big     = (ms > mo) ? ms : mo;
    small_m = (ms > mo) ? mo : ms;
    fnm     = fn[63] ? 64'(-fn) : 64'(fn);
    vdm     = vd[63] ? 64'(-vd) : 64'(vd);
    is_arith = !(state == ST_IDLE || state == ST_SH || state == ST_DONE);
    skip_md  = (state == ST_MD) && (big == '0);
    t_big    = (at[0][63:31] != '0) || (at[1][63:31] != '0) || (at[2][63:31] != '0);
    t_new    = 64'(vs[k]) - signed_of({30'd0, rsp.lo[63:30]}, vd[63] ^ dneg[k]);
  end

  // operand selection for the shared unit
  always_comb begin
    req.start = is_arith && !issued && !skip_md;
    req.op    = OP_MUL;
    req.a     = '0;
    req.b     = '0;
    unique case (state)
      ST_D2:  begin req.a = 64'(ad[k]);      req.b = 64'(ad[k]); end
      ST_SS:  begin req.a = 64'(s_sum);      req.b = 64'(s_sum); end
      ST_SQD: begin req.op = OP_SQRT;        req.a = d2; end
      ST_RR:  begin req.a = 64'(rs);         req.b = 64'(ro); end
      ST_RQ8: begin req.op = OP_DIV;         req.a = tmp; req.b = 64'(s_sum); end
      ST_RD:  begin req.a = rq8;             req.b = 64'(delta); end
      ST_SQA: begin req.op = OP_SQRT;        req.a = tmp; end
      ST_ED:  begin req.a = 64'(modulus);    req.b = 64'(delta); end
      ST_AK:  begin req.a = 64'(a_root);     req.b = KQ48; end
      ST_FE:  begin req.a = ea;              req.b = tmp; end
      ST_MD:  begin
        req.op = OP_DIV;
        req.a  = {2'b00, big, 22'd0};
        req.b  = 64'(big) + 64'(small_m);
      end
      ST_MS:  begin req.a = 64'(small_m);    req.b = tmp; end
      ST_EM:  begin req.a = 64'(modulus);    req.b = mstar; end
      ST_SQG: begin req.op = OP_SQRT;        req.a = tmp; end
      ST_GC:  begin req.a = tmp;             req.b = CQ; end
      ST_TZ:  begin req.a = 64'(damping);    req.b = tmp; end
      ST_SQB: begin req.op = OP_SQRT;        req.a = 64'(a_root) << 20; end
      ST_TB:  begin req.a = damp_t;          req.b = 64'(b_root); end
      ST_VD:  begin req.a = 64'(vm[k]);      req.b = 64'(ad[k]); end
      ST_VN:  begin req.op = OP_DIV;         req.a = vdm; req.b = 64'(centre_dist); end
      ST_FD:  begin req.a = tb;              req.b = vnm; end
      ST_NQ:  begin
        req.op = OP_DIV;
        req.a  = 64'(ad[k]) << 30;
        req.b  = 64'(centre_dist);
      end
      ST_CF:  begin req.a = fnm;             req.b = nq; end
      ST_PM:  begin req.a = vnm;             req.b = nq; end
      ST_T2:  begin req.a = at[k];           req.b = at[k]; end
      ST_SQT: begin req.op = OP_SQRT;        req.a = s2; end
      ST_FF:  begin req.a = fnm;             req.b = 64'(friction); end
      ST_U:   begin req.op = OP_DIV;         req.a = at[k] << 30; req.b = 64'(tn); end
      ST_FR:  begin req.a = ff;              req.b = nq; end
      default: begin req.start = 1'b0; end
    endcase
  end

  // clipped product and saturating accumulate
  always_comb begin
    case (state)
      ST_FE:   sh_amt = 6'd32;
      ST_FD:   sh_amt = 6'd29;
      ST_FF:   sh_amt = 6'd16;
      ST_CF,
      ST_FR:   sh_amt = 6'd30;
      default: sh_amt = 6'd0;
    endcase
    msh = mulsh({rsp.hi, rsp.lo}, sh_amt);
    if (state == ST_FR) begin
      sat_s = friction_sum[k];
      sat_x = signed_of(msh[63:0], tneg[k]);
    end else begin
      sat_s = contact_sum[k];
      sat_x = signed_of(msh[63:0], fn[63] ^ dneg[k]);
    end
    sat = sat_add(sat_s, sat_x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= MODULUS_RST;
      damping  <= DAMPING_RST;
      friction <= FRICTION_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULUS:  modulus  <= cfg_data;
        REG_DAMPING:  damping  <= cfg_data[15:0];
        REG_FRICTION: friction <= cfg_data[15:0];
        default:      modulus  <= modulus;
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issued    <= 1'b0;
      k         <= '0;
      clip_flag <= 1'b0;
      m_tvalid  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        contact_sum[i]  <= '0;
        friction_sum[i] <= '0;
      end
    end else begin
      if (m_tvalid && m_tready && !(state == ST_DONE && last)) m_tvalid <= 1'b0;
      if (req.start) issued <= 1'b1;
      if (rsp.done) issued <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            k     <= '0;
            state <= s_tuser ? ST_DONE : ST_D2;
          end
        end
        ST_D2: if (rsp.done) begin
          k     <= (k == 2'd2) ? 2'd0 : k + 2'd1;
          state <= (k == 2'd2) ? ST_SS : ST_D2;
        end
        ST_SS: if (rsp.done) begin
          state <= (d2 == '0 || d2 >= rsp.lo) ? ST_DONE : ST_SQD;
        end
        ST_SQD: if (rsp.done) state <= ST_RR;
        ST_RR:  if (rsp.done) state <= ST_RQ8;
        ST_RQ8: if (rsp.done) state <= ST_RD;
        ST_RD:  if (rsp.done) state <= ST_SQA;
        ST_SQA: if (rsp.done) state <= ST_ED;
        ST_ED:  if (rsp.done) state <= ST_AK;
        ST_AK:  if (rsp.done) state <= ST_FE;
        ST_FE: if (rsp.done) begin
          clip_flag <= clip_flag | msh[64];
          state     <= ST_MD;
        end
        ST_MD: begin
          if (skip_md) state <= ST_EM;
          else if (rsp.done) state <= ST_MS;
        end
        ST_MS:  if (rsp.done) state <= ST_EM;
        ST_EM:  if (rsp.done) state <= ST_SQG;
        ST_SQG: if (rsp.done) state <= ST_GC;
        ST_GC:  if (rsp.done) state <= ST_TZ;
        ST_TZ:  if (rsp.done) state <= ST_SQB;
        ST_SQB: if (rsp.done) state <= ST_TB;
        ST_TB:  if (rsp.done) begin
          k     <= '0;
          state <= ST_VD;
        end
        ST_VD: if (rsp.done) begin
          k     <= (k == 2'd2) ? 2'd0 : k + 2'd1;
          state <= (k == 2'd2) ? ST_VN : ST_VD;
        end
        ST_VN: if (rsp.done) state <= ST_FD;
        ST_FD: if (rsp.done) begin
          clip_flag <= clip_flag | msh[64];
          k         <= '0;
          state     <= ST_NQ;
        end
        ST_NQ: if (rsp.done) state <= ST_CF;
        ST_CF: if (rsp.done) begin
          contact_sum[k] <= sat[SUM_WIDTH-1:0];
          clip_flag      <= clip_flag | msh[64] | sat[SUM_WIDTH];
          state          <= ST_PM;
        end
        ST_PM: if (rsp.done) begin
          k     <= (k == 2'd2) ? 2'd0 : k + 2'd1;
          state <= (k == 2'd2) ? ST_SH : ST_NQ;
        end
        ST_SH: if (!t_big) state <= ST_T2;
        ST_T2: if (rsp.done) begin
          k     <= (k == 2'd2) ? 2'd0 : k + 2'd1;
          state <= (k == 2'd2) ? ST_SQT : ST_T2;
        end
        ST_SQT: if (rsp.done) state <= (rsp.lo == '0) ? ST_DONE : ST_FF;
        ST_FF: if (rsp.done) begin
          clip_flag <= clip_flag | msh[64];
          k         <= '0;
          state     <= ST_U;
        end
        ST_U: if (rsp.done) state <= ST_FR;
        ST_FR: if (rsp.done) begin
          friction_sum[k] <= sat[SUM_WIDTH-1:0];
          clip_flag       <= clip_flag | msh[64] | sat[SUM_WIDTH];
          k               <= (k == 2'd2) ? 2'd0 : k + 2'd1;
          state           <= (k == 2'd2) ? ST_DONE : ST_U;
        end
        ST_DONE: begin
          if (!last) begin
            state <= ST_IDLE;
          end else if (!m_tvalid || m_tready) begin
            m_tvalid  <= 1'b1;
            clip_flag <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              contact_sum[i]  <= '0;
              friction_sum[i] <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      for (int i = 0; i < 3; i++) begin
        ad[i]   <= s_tdata[32*i+31] ? 32'(-s_tdata[32*i +: 32]) : s_tdata[32*i +: 32];
        dneg[i] <= s_tdata[32*i+31];
        vs[i]   <= $signed(s_tdata[96+32*i +: 32]);
        vm[i]   <= s_tdata[96+32*i+31] ? 32'(-s_tdata[96+32*i +: 32])
                                       : s_tdata[96+32*i +: 32];
        vneg[i] <= s_tdata[96+32*i+31];
      end
      rs    <= s_tdata[215:192];
      ro    <= s_tdata[239:216];
      ms    <= s_tdata[279:240];
      mo    <= s_tdata[319:280];
      s_sum <= 25'(s_tdata[215:192]) + 25'(s_tdata[239:216]);
      last  <= s_tlast;
      d2    <= '0;
      vd    <= '0;
    end
    if (rsp.done) begin
      case (state)
        ST_D2:  d2     <= d2 + rsp.lo;
        ST_SQD: begin
          centre_dist <= rsp.lo[31:0];
          delta       <= s_sum - rsp.lo[24:0];
        end
        ST_RR:  tmp    <= rsp.lo << 8;
        ST_RQ8: rq8    <= rsp.lo;
        ST_RD:  tmp    <= rsp.lo << 4;
        ST_SQA: a_root <= rsp.lo[31:0];
        ST_ED:  ea     <= rsp.lo;
        ST_AK:  tmp    <= rsp.lo;
        ST_FE:  fe     <= msh[63:0];
        ST_MD:  tmp    <= rsp.lo;
        ST_MS:  mstar  <= rsp.lo >> 22;
        ST_EM:  tmp    <= rsp.lo << 3;
        ST_SQG: tmp    <= rsp.lo;
        ST_GC:  tmp    <= rsp.lo >> 25;
        ST_TZ:  damp_t <= rsp.lo >> 15;
        ST_SQB: b_root <= rsp.lo[31:0];
        ST_TB:  tb     <= rsp.lo;
        ST_VD:  vd     <= vd + signed_of(rsp.lo, vneg[k] ^ dneg[k]);
        ST_VN:  vnm    <= rsp.lo;
        ST_FD:  fn     <= signed_of(msh[63:0], vd[63]) - $signed(fe);
        ST_NQ:  nq     <= rsp.lo;
        ST_PM: begin
          at[k]   <= t_new[63] ? 64'(-t_new) : 64'(t_new);
          tneg[k] <= t_new[63];
          s2      <= '0;
        end
        ST_T2:  s2     <= s2 + rsp.lo;
        ST_SQT: tn     <= rsp.lo[31:0];
        ST_FF:  ff     <= msh[63:0];
        ST_U:   nq     <= rsp.lo;
        default: tmp   <= tmp;
      endcase
    end
    if (state == ST_MD && skip_md) mstar <= '0;
    // common right shift until every tangential component fits 31 bits
    if (state == ST_SH && t_big) begin
      for (int i = 0; i < 3; i++) at[i] <= at[i] >> 1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == ST_DONE && last && (!m_tvalid || m_tready)) begin
      for (int i = 0; i < 3; i++) begin
        m_tdata[48*i +: 48]     <= 48'(64'(contact_sum[i]));
        m_tdata[144+48*i +: 48] <= 48'(64'(friction_sum[i]));
      end
      m_tuser <= clip_flag;
    end
  end

`ifndef SYNTHESIS
  a_done_issued: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> issued)
    else $error("shared unit finished without a request");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !issued)
    else $error("request outstanding while idle");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && last && (!m_tvalid || m_tready)) |=>
      (m_tvalid && !clip_flag && contact_sum[0] == '0 && friction_sum[0] == '0))
    else $error("sums not cleared on emit");
`endif

endmodule

/* dv/tb.sv */
// Testbench for hertz_pair_contact_force_top: directed and random neighbour pairs,
// a scoreboard class that predicts the summed forces, randomised stream back-pressure.
// Depends on hpcf_pkg (register indexes) and the block's RTL.
module tb;
  import hpcf_pkg::*;

  localparam longint CYCLE_LIMIT = 8000000;
  localparam int     SETTLE      = 2500;

  typedef struct {
    bit [31:0] pos[3];
    bit [31:0] vel[3];
    bit [23:0] rs, ro;
    bit [39:0] ms, mo;
    bit        self_p, last;
  } pair_t;

  typedef struct {
    bit [47:0] c[3];
    bit [47:0] f[3];
    bit        sat;
  } force_t;

  class force_scoreboard;
    bit [63:0] modulus, damping, friction;
    longint    csum[3], fsum[3];
    bit        clip;
    force_t    pending[$];
    int        errors;

    function new();
      modulus = 109890; damping = 6554; friction = 6554;
      for (int k = 0; k < 3; k++) begin
        csum[k] = 0; fsum[k] = 0;
      end
      clip = 0; errors = 0;
    endfunction

    function void set_reg(bit [1:0] idx, bit [19:0] val);
      case (idx)
        REG_MODULUS:  modulus = 64'(val);
        REG_DAMPING:  damping = 64'(val[15:0]);
        REG_FRICTION: friction = 64'(val[15:0]);
        default: ;
      endcase
    endfunction

    function bit [63:0] root(bit [63:0] v);
      bit [63:0] r, b;
      r = 0; b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b); r = (r >> 1) + b;
        end else r >>= 1;
        b >>= 2;
      end
      return r;
    endfunction

    function bit [63:0] mul_shift(bit [63:0] a, bit [63:0] b, int sh);
      bit [127:0] p;
      p = ({64'd0, a} * {64'd0, b}) >> sh;
      if (p[127:62] != 0) begin
        clip = 1;
        return 64'h3FFF_FFFF_FFFF_FFFF;
      end
      return p[63:0];
    endfunction

    function bit [63:0] magn(bit [63:0] v);
      return $signed(v) < 0 ? -v : v;
    endfunction

    function bit [63:0] apply_sign(bit [63:0] m, bit neg);
      return neg ? -m : m;
    endfunction

    function longint clamp_add(longint s, longint x);
      longint lim;
      lim = (64'sd1 <<< 47) - 1;
      if (x > 0 && s > lim - x) begin
        clip = 1; return lim;
      end
      if (x < 0 && s < -lim - 1 - x) begin
        clip = 1; return -lim - 1;
      end
      return s + x;
    endfunction

    function void add_contact(pair_t p);
      bit [63:0] d[3], v[3], t[3], ad[3], at[3];
      bit [63:0] rs, ro, ms, mo, d2, s, cdist, delta, rq8, a, fe, big, sml, mstar, g, tq, b;
      bit [63:0] vd, vnm, fd, fn, fnm, tmax, s2, tn, ff, nq, c, pm, u, fk;
      bit        vneg, dneg;
      int        sh;
      for (int k = 0; k < 3; k++) begin
        d[k] = {{32{p.pos[k][31]}}, p.pos[k]};
        v[k] = {{32{p.vel[k][31]}}, p.vel[k]};
        ad[k] = magn(d[k]);
      end
      rs = p.rs; ro = p.ro; ms = p.ms; mo = p.mo;
      d2 = ad[0] * ad[0] + ad[1] * ad[1] + ad[2] * ad[2];
      s = rs + ro;
      if (d2 == 0 || d2 >= s * s) return;
      cdist = root(d2);
      delta = s - cdist;
      rq8 = ((rs * ro) << 8) / s;
      a = root(rq8 * delta * 16);
      fe = mul_shift(modulus * delta, a * 64'd89478485, 32);
      big = ms > mo ? ms : mo;
      sml = ms > mo ? mo : ms;
      mstar = 0;
      if (big != 0) mstar = (sml * ((big << 22) / (big + sml))) >> 22;
      g = (root(8 * modulus * mstar) * 64'd34769611) >> 25;
      tq = (damping * g) >> 15;
      b = root(a << 20);
      vd = v[0] * d[0] + v[1] * d[1] + v[2] * d[2];
      vnm = magn(vd) / cdist;
      vneg = $signed(vd) < 0;
      fd = mul_shift(tq * b, vnm, 29);
      fn = apply_sign(fd, vneg) - fe;
      fnm = magn(fn);
      tmax = 0;
      for (int k = 0; k < 3; k++) begin
        nq = (ad[k] << 30) / cdist;
        dneg = $signed(d[k]) < 0;
        c = mul_shift(fnm, nq, 30);
        csum[k] = clamp_add(csum[k], $signed(apply_sign(c, ($signed(fn) < 0) != dneg)));
        pm = (vnm * nq) >> 30;
        t[k] = v[k] - apply_sign(pm, vneg != dneg);
        at[k] = magn(t[k]);
        if (at[k] > tmax) tmax = at[k];
      end
      sh = 0;
      while ((tmax >> sh) >= (64'd1 << 31)) sh++;
      s2 = 0;
      for (int k = 0; k < 3; k++) begin
        at[k] >>= sh;
        s2 += at[k] * at[k];
      end
      tn = root(s2);
      if (tn == 0) return;
      ff = mul_shift(fnm, friction, 16);
      for (int k = 0; k < 3; k++) begin
        u = (at[k] << 30) / tn;
        fk = mul_shift(ff, u, 30);
        fsum[k] = clamp_add(fsum[k], $signed(apply_sign(fk, $signed(t[k]) < 0)));
      end
    endfunction

    // called for every accepted pair
    function void note_pair(pair_t p);
      force_t e;
      if (!p.self_p) add_contact(p);
      if (!p.last) return;
      for (int k = 0; k < 3; k++) begin
        e.c[k] = csum[k][47:0];
        e.f[k] = fsum[k][47:0];
        csum[k] = 0; fsum[k] = 0;
      end
      e.sat = clip;
      clip = 0;
      pending.push_back(e);
    endfunction

    function void check_result(bit [287:0] data, bit sat);
      force_t e;
      string  axis[3];
      axis = '{"x", "y", "z"};
      if (pending.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
        return;
      end
      e = pending.pop_front();
      for (int k = 0; k < 3; k++) begin
        if (data[48*k +: 48] != e.c[k]) begin
          $error("contact_force_%s: expected %h, got %h", axis[k], e.c[k], data[48*k +: 48]);
          errors++;
        end
        if (data[144 + 48*k +: 48] != e.f[k]) begin
          $error("friction_force_%s: expected %h, got %h", axis[k], e.f[k],
                 data[144 + 48*k +: 48]);
          errors++;
        end
      end
      if (sat != e.sat) begin
        $error("saturated: expected %0d, got %0d", e.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [19:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [319:0] s_tdata;
  logic         s_tuser;
  logic         s_tlast;
  logic         m_tvalid;
  logic         m_tready;
  logic [287:0] m_tdata;
  logic         m_tuser;

  force_scoreboard sb = new();
  int     idle_mode;   // 0 none, 1 sender, 2 receiver, 3 both
  longint cycles;

  hertz_pair_contact_force_top dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function bit sender_idles();
    if (idle_mode == 1) return $urandom_range(0, 99) < 73;
    if (idle_mode == 3) return $urandom_range(0, 99) < 18;
    return 0;
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    if (idle_mode == 2) m_tready <= $urandom_range(0, 99) >= 73;
    else if (idle_mode == 3) m_tready <= $urandom_range(0, 99) >= 18;
    else m_tready <= 1'b1;
  end

  task automatic send_pair(pair_t p);
    if (sender_idles()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while (sender_idles()) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {p.mo, p.ms, p.ro, p.rs, p.vel[2], p.vel[1], p.vel[0],
                p.pos[2], p.pos[1], p.pos[0]};
    s_tuser <= p.self_p;
    s_tlast <= p.last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_pair(p);
  endtask

  task automatic write_reg(bit [1:0] idx, bit [19:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic pair_t mk(int px, int py, int pz, int vx, int vy, int vz,
                               bit [23:0] rs, bit [23:0] ro, bit [39:0] ms, bit [39:0] mo,
                               bit self_p, bit last);
    pair_t p;
    p.pos = '{px, py, pz};
    p.vel = '{vx, vy, vz};
    p.rs = rs; p.ro = ro; p.ms = ms; p.mo = mo;
    p.self_p = self_p; p.last = last;
    return p;
  endfunction

  task automatic run_directed();
    send_pair(mk(3000, -4000, 0, 100000, 20000, -5000, 10000, 10000, 1000000, 1000000, 0, 1));
    send_pair(mk(3000, -4000, 0, 100000, 20000, -5000, 10000, 10000, 1000000, 1000000, 1, 1));
    // coincident centres
    send_pair(mk(0, 0, 0, 5000, 5000, 5000, 10000, 10000, 1000, 1000, 0, 1));
    // velocity along the normal only: no friction
    send_pair(mk(6000, 0, 0, -50000, 0, 0, 5000, 5000, 4000000, 7000000, 0, 1));
    send_pair(mk(-32'sd2147483648, 32'sd2147483647, -32'sd2147483648, 32'sd2147483647,
                 -32'sd2147483648, 0, 24'hFFFFFF, 24'hFFFFFF, '1, '1, 0, 1));
    // biggest particles: huge products and sum overflow over one run
    for (int i = 0; i < 4; i++)
      send_pair(mk(-1000000, 2000000, 1, 32'sd2147483647, -32'sd2147483648, 32'sd2147483647,
                   24'hFFFFFF, 24'hFFFFFF, '1, '1, 0, i == 3));
    send_pair(mk(100, 200, -300, -70000, 80000, 9000, 2000, 3000, 0, 0, 0, 1));
    send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    send_pair(mk(10, 0, 0, 3, 99, -7, 0, 1000, 1, '1, 0, 1));
    send_pair(mk(-1, -1, -1, -1, -1, -1, 1, 1, 1, 1, 0, 0));
    send_pair(mk(-5000, 100, 2000, -123456, 654321, 0, 8000, 4000, 77, 5000000, 0, 0));
    send_pair(mk(1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 1, 0));
    send_pair(mk(-2, 7, 1, 0, 0, 0, 5, 5, 5, 5, 0, 1));
  endtask

  function automatic int rand_vel();
    if ($urandom_range(0, 1)) return $urandom;
    return int'($urandom_range(0, 2000000)) - 1000000;
  endfunction

  function automatic pair_t rand_pair(bit last);
    pair_t p;
    int    r, sum, half;
    r = $urandom_range(0, 99);
    for (int k = 0; k < 3; k++) begin
      p.pos[k] = $urandom;
      p.vel[k] = rand_vel();
    end
    p.ms = 40'({$urandom, $urandom} >> $urandom_range(0, 39));
    p.mo = 40'({$urandom, $urandom} >> $urandom_range(0, 39));
    p.self_p = (r < 10);
    p.last = last;
    if (r < 30) begin
      p.rs = 24'($urandom);
      p.ro = 24'($urandom);
    end else begin
      p.rs = 24'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 14));
      p.ro = 24'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 14));
      sum = p.rs + p.ro;
      half = sum / 2;
      for (int k = 0; k < 3; k++) p.pos[k] = int'($urandom_range(0, sum)) - half;
    end
    return p;
  endfunction

  task automatic run_random(int count);
    int n, len;
    n = 0;
    while (n < count) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        send_pair(rand_pair(i == len - 1));
        n++;
      end
    end
  endtask

  initial begin
    bit [19:0] cfg[5][3];
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0; s_tlast = 1'b0;
    m_tready = 1'b0;
    idle_mode = 0;
    cycles = 0;
    cfg[0] = '{20'd109890, 20'd6554, 20'd6554};
    cfg[1] = '{20'd0, 20'd0, 20'd0};
    cfg[2] = '{20'hFFFFF, 20'hFFFF, 20'hFFFF};
    cfg[3] = '{20'($urandom), 20'($urandom_range(0, 16'hFFFF)), 20'($urandom_range(0, 16'hFFFF))};
    cfg[4] = '{20'($urandom), 20'($urandom_range(0, 16'hFFFF)), 20'($urandom_range(0, 16'hFFFF))};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_MODULUS, cfg[ph][0]);
      write_reg(REG_DAMPING, cfg[ph][1]);
      write_reg(REG_FRICTION, cfg[ph][2]);
      idle_mode = ph % 4;
      if (ph == 0 || ph == 2) run_directed();
      run_random(150);
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
